// ===== rtl/core/cbs_pkg.sv =====
// Package: shared widths, types, register codes and helpers for the cell balance selector.
package cbs_pkg;

  localparam int NUM_CELLS = 5;
  localparam int CELL_W    = 23;
  localparam int CUR_W     = 16;
  localparam int THR_W     = 20;
  // 5 * cell and the five-cell sum both fit in 26 bits; the deviation needs a sign bit more
  localparam int SUM_W     = 26;
  localparam int DEV_W     = SUM_W + 1;
  localparam int IDX_W     = $clog2(NUM_CELLS);
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [THR_W-1:0] THR_HIGH_RST = THR_W'(10000);
  localparam logic [THR_W-1:0] THR_LOW_RST  = THR_W'(5000);

  // Register index, taken from paddr[2]
  localparam logic REG_THR_HIGH = 1'b0;
  localparam logic REG_THR_LOW  = 1'b1;

  typedef logic [CELL_W-1:0]       cell_t;
  typedef logic [SUM_W-1:0]        sum_t;
  typedef logic signed [DEV_W-1:0] dev_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [NUM_CELLS-1:0]    mask_t;
  typedef cell_t [NUM_CELLS-1:0]   cell_vec_t;
  typedef dev_t  [NUM_CELLS-1:0]   dev_vec_t;

  // Winner of the lane merge
  typedef struct packed {
    dev_t best;
    idx_t idx;
  } merge_res_t;

  // 5 * x without a multiplier
  function automatic sum_t times5(input logic [SUM_W-1:0] x);
    times5 = x + {x[SUM_W-3:0], 2'b00};
  endfunction

  function automatic mask_t onehot(input idx_t idx);
    onehot = mask_t'(1) << idx;
  endfunction

endpackage

// ===== rtl/core/cbs_meas_if.sv =====
// Interface: measurement request channel (five cell voltages and coulomb-counter code).
interface cbs_meas_if
  import cbs_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [CELL_W-1:0]       cell1_uv;
  logic [CELL_W-1:0]       cell2_uv;
  logic [CELL_W-1:0]       cell3_uv;
  logic [CELL_W-1:0]       cell4_uv;
  logic [CELL_W-1:0]       cell5_uv;
  logic signed [CUR_W-1:0] current_raw;

  modport source (output valid, cell1_uv, cell2_uv, cell3_uv, cell4_uv, cell5_uv,
                  current_raw, input ready);
  modport sink   (input valid, cell1_uv, cell2_uv, cell3_uv, cell4_uv, cell5_uv,
                  current_raw, output ready);
endinterface

// ===== rtl/core/cbs_bal_if.sv =====
// Interface: balance result channel (bleed mask and write flag).
interface cbs_bal_if
  import cbs_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [NUM_CELLS-1:0] balance_mask;
  logic                 mask_written;

  modport source (output valid, balance_mask, mask_written, input ready);
  modport sink   (input valid, balance_mask, mask_written, output ready);
endinterface

// ===== rtl/core/cbs_lane.sv =====
// Lane: registered deviation 5*v - sum for one cell.
module cbs_lane
  import cbs_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  cell_t volt,
  input  sum_t  sum,
  output dev_t  dev
);

  dev_t dev_next;

  // Scale the cell by five and take off the stack sum
  always_comb begin
    dev_next = $signed({1'b0, times5(SUM_W'(volt))}) - $signed({1'b0, sum});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dev <= dev_next;
    end
  end

endmodule

// ===== rtl/core/cbs_merge.sv =====
// Merge: registered arg-max over the lane deviations, lowest cell wins a tie.
module cbs_merge
  import cbs_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  dev_vec_t   dev,
  output merge_res_t res
);

  dev_t       best01, best23, best03;
  idx_t       idx01, idx23, idx03;
  merge_res_t res_next;

  // Pairwise tree; a later cell replaces only on strictly greater
  always_comb begin
    best01 = dev[0];
    idx01  = idx_t'(0);
    if ($signed(dev[1]) > $signed(dev[0])) begin
      best01 = dev[1];
      idx01  = idx_t'(1);
    end
    best23 = dev[2];
    idx23  = idx_t'(2);
    if ($signed(dev[3]) > $signed(dev[2])) begin
      best23 = dev[3];
      idx23  = idx_t'(3);
    end
    best03 = best01;
    idx03  = idx01;
    if ($signed(best23) > $signed(best01)) begin
      best03 = best23;
      idx03  = idx23;
    end
    res_next.best = best03;
    res_next.idx  = idx03;
    if ($signed(dev[4]) > $signed(best03)) begin
      res_next.best = dev[4];
      res_next.idx  = idx_t'(4);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule

// ===== rtl/core/cell_balance_selector.sv =====
// Top level: five-cell passive balancing selector with hysteresis and APB threshold registers.
//
//   channel   dir  handshake      payload
//   measure   in   valid/ready    cell1_uv..cell5_uv (23b), current_raw (16b signed)
//   balance   out  valid/ready    balance_mask (5b, one-hot or zero), mask_written (1b)
//   apb       in   psel/penable   threshold_high_uv @0x0, threshold_low_uv @0x4
//
// One request enters per cycle while the pipeline is not stalled; its result passes through
// four register stages: sum, five deviation lanes, lane merge, threshold decision into
// the output register (the first loads at the accepting edge).
// Each stage holds when the one after it is full and stalled, so bubbles still fill
// while a result waits. Reset clears all stage valids, the active mask and sets the
// thresholds to 10000 uV and 5000 uV. The active mask is updated in request order.
module cell_balance_selector
  import cbs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  cbs_meas_if.sink           measure,
  cbs_bal_if.source          balance,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  logic [THR_W-1:0] thr_high, thr_low;

  logic       v1, v2, v3, v4;
  logic       rdy1, rdy2, rdy3, rdy4;
  logic       chg1, chg2, chg3;
  cell_vec_t  cell1;
  sum_t       sum1;
  dev_vec_t   dev2;
  merge_res_t res3;

  logic  charging;
  sum_t  sum_next;
  dev_t  high5, low5;
  mask_t mask_next;
  logic  written_next;
  mask_t active_mask;
  logic  mask_written;

  // Configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_high <= THR_HIGH_RST;
      thr_low  <= THR_LOW_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_THR_HIGH: thr_high <= pwdata[THR_W-1:0];
        REG_THR_LOW:  thr_low  <= pwdata[THR_W-1:0];
        default:      thr_high <= thr_high;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_THR_HIGH: prdata = DATA_W'(thr_high);
      REG_THR_LOW:  prdata = DATA_W'(thr_low);
      default:      prdata = '0;
    endcase
  end

  // Stage handshakes: a stage loads when empty or when its content moves on
  assign rdy4 = !v4 || balance.ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign measure.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= measure.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // Stage 1: capture cells, stack sum and charging flag (codes of +1 and -1 count as zero)
  assign charging = measure.current_raw > $signed(CUR_W'(1));
  assign sum_next = SUM_W'(measure.cell1_uv) + SUM_W'(measure.cell2_uv)
                  + SUM_W'(measure.cell3_uv) + SUM_W'(measure.cell4_uv)
                  + SUM_W'(measure.cell5_uv);

  always_ff @(posedge clk) begin
    if (rdy1 && measure.valid) begin
      cell1[0] <= measure.cell1_uv;
      cell1[1] <= measure.cell2_uv;
      cell1[2] <= measure.cell3_uv;
      cell1[3] <= measure.cell4_uv;
      cell1[4] <= measure.cell5_uv;
      sum1     <= sum_next;
      chg1     <= charging;
    end
  end

  // Stage 2: one deviation lane per cell
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_lane
    cbs_lane u_lane (
      .clk  (clk),
      .en   (rdy2 && v1),
      .volt (cell1[g]),
      .sum  (sum1),
      .dev  (dev2[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      chg2 <= chg1;
    end
  end

  // Stage 3: pick the largest deviation
  cbs_merge u_merge (
    .clk (clk),
    .en  (rdy3 && v2),
    .dev (dev2),
    .res (res3)
  );

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      chg3 <= chg2;
    end
  end

  // Stage 4: threshold decision with hysteresis
  assign high5 = $signed({1'b0, times5(SUM_W'(thr_high))});
  assign low5  = $signed({1'b0, times5(SUM_W'(thr_low))});

  always_comb begin
    mask_next    = '0;
    written_next = 1'b1;
    priority if (!chg3) begin
      mask_next = '0;
    end else if ($signed(res3.best) > high5) begin
      mask_next = onehot(res3.idx);
    end else if ($signed(res3.best) < low5) begin
      mask_next = '0;
    end else begin
      mask_next    = active_mask;
      written_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_mask <= '0;
    end else if (rdy4 && v3) begin
      active_mask <= mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      mask_written <= written_next;
    end
  end

  assign balance.valid        = v4;
  assign balance.balance_mask = active_mask;
  assign balance.mask_written = mask_written;

endmodule

// ===== tb/cell_balance_selector_tb.sv =====
// Testbench: self-checking stimulus, prediction and result checks for the cell balance selector.
module cell_balance_selector_tb;
  import cbs_pkg::*;

  localparam int unsigned CELL_MAX       = (1 << CELL_W) - 1;
  localparam int unsigned V_NOM          = 3700000;
  localparam int          MAX_WAIT       = 17;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          REPORT_LIMIT   = 10;

  // One measurement request: cells[0] is cell 1
  typedef struct packed {
    logic signed [CUR_W-1:0] cur;
    cell_t [NUM_CELLS-1:0]   cells;
  } meas_t;

  // One balance result
  typedef struct packed {
    mask_t mask;
    logic  written;
  } bal_res_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  cbs_meas_if meas ();
  cbs_bal_if  bal ();

  cell_balance_selector i_dut (
    .clk     (clk),
    .rst     (rst),
    .measure (meas),
    .balance (bal),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the block's thresholds and bleed mask
  logic [THR_W-1:0] hi_thr_uv  = THR_HIGH_RST;
  logic [THR_W-1:0] lo_thr_uv  = THR_LOW_RST;
  mask_t            bleed_mask = '0;

  bal_res_t balance_expect_q[$];
  int       fail_count   = 0;
  int       meas_gap     = 0;
  int       out_hold_cnt = 0;
  bit       burst        = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Work out the result of one request and advance the shadow mask
  function automatic bal_res_t predict_balance(input meas_t m);
    bal_res_t r;
    longint   total;
    longint   dev;
    longint   best;
    int       best_cell;
    int       cur;
    cur       = int'(m.cur);
    r.written = 1'b1;
    if (cur == 1 || cur == -1) cur = 0;
    if (cur <= 0) begin
      bleed_mask = '0;
    end else begin
      total = 0;
      for (int i = 0; i < NUM_CELLS; i++) total += longint'(m.cells[i]);
      best      = 5 * longint'(m.cells[0]) - total;
      best_cell = 0;
      for (int i = 1; i < NUM_CELLS; i++) begin
        dev = 5 * longint'(m.cells[i]) - total;
        // strict compare keeps the lowest cell on a tie
        if (dev > best) begin
          best      = dev;
          best_cell = i;
        end
      end
      if (best > 5 * longint'(hi_thr_uv)) begin
        bleed_mask = mask_t'(1) << best_cell;
      end else if (best < 5 * longint'(lo_thr_uv)) begin
        bleed_mask = '0;
      end else begin
        r.written = 1'b0;
      end
    end
    r.mask = bleed_mask;
    return r;
  endfunction

  function automatic meas_t cells_req(input int unsigned c1, c2, c3, c4, c5, input int cur);
    meas_t m;
    m.cells[0] = cell_t'(c1);
    m.cells[1] = cell_t'(c2);
    m.cells[2] = cell_t'(c3);
    m.cells[3] = cell_t'(c4);
    m.cells[4] = cell_t'(c5);
    m.cur      = CUR_W'(cur);
    return m;
  endfunction

  // Mostly charging packs around a nominal voltage, some aimed at a threshold; rest is noise
  function automatic meas_t rand_meas();
    meas_t       m;
    int unsigned kind;
    int unsigned base;
    int unsigned spread;
    int unsigned pick;
    int unsigned aim;
    int          delta;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      for (int i = 0; i < NUM_CELLS; i++) m.cells[i] = cell_t'($urandom);
      m.cur = CUR_W'($urandom);
    end else begin
      base = $urandom_range(2500000, 4300000);
      case ($urandom_range(0, 3))
        0: spread = 0;
        1: spread = 2 * lo_thr_uv + 8;
        2: spread = 3 * hi_thr_uv + 8;
        default: spread = 200000;
      endcase
      for (int i = 0; i < NUM_CELLS; i++) m.cells[i] = cell_t'(base + $urandom_range(0, spread));
      if (kind <= 3) begin
        // put one cell within a few uV of a threshold, the rest level
        aim   = $urandom_range(0, 1) ? hi_thr_uv : lo_thr_uv;
        delta = int'((5 * aim) / 4) + int'($urandom_range(0, 4)) - 2;
        if (delta < 0) delta = 0;
        pick = $urandom_range(0, NUM_CELLS - 1);
        for (int i = 0; i < NUM_CELLS; i++) m.cells[i] = cell_t'(base);
        m.cells[pick] = cell_t'(base + delta);
        if (kind == 1) m.cells[(pick + 1 + $urandom_range(0, 3)) % NUM_CELLS] = m.cells[pick];
      end
      case ($urandom_range(0, 9))
        0: m.cur = CUR_W'(int'($urandom_range(0, 2)) - 1);
        1: m.cur = CUR_W'(-int'($urandom_range(2, 32768)));
        default: m.cur = CUR_W'($urandom_range(2, 32767));
      endcase
    end
    return m;
  endfunction

  // Offer one request, hold it until accepted, then log its prediction
  task automatic send_meas(input meas_t m);
    repeat (meas_gap) @(posedge clk);
    meas.valid       <= 1'b1;
    meas.cell1_uv    <= m.cells[0];
    meas.cell2_uv    <= m.cells[1];
    meas.cell3_uv    <= m.cells[2];
    meas.cell4_uv    <= m.cells[3];
    meas.cell5_uv    <= m.cells[4];
    meas.current_raw <= m.cur;
    do @(posedge clk); while (!(meas.valid && meas.ready));
    balance_expect_q.push_back(predict_balance(m));
    // keep valid up when the next request follows at once
    meas_gap = burst ? 0 : $urandom_range(0, MAX_WAIT);
    if (meas_gap != 0) meas.valid <= 1'b0;
  endtask

  // Drop valid and wait until every result is in and the pipeline is empty
  task automatic settle();
    if (meas_gap == 0) meas.valid <= 1'b0;
    meas_gap = 0;
    while (balance_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both threshold registers back to back over APB
  task automatic write_thresholds(input int unsigned hi, input int unsigned lo);
    logic        reg_sel;
    int unsigned value;
    for (int r = 0; r < 2; r++) begin
      reg_sel = (r == 0) ? REG_THR_HIGH : REG_THR_LOW;
      value   = (r == 0) ? hi : lo;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= DATA_W'(value);
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (reg_sel == REG_THR_HIGH) hi_thr_uv = THR_W'(value);
      else lo_thr_uv = THR_W'(value);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Field extremes, current codes around zero, ties and exact threshold hits at reset thresholds
  task automatic test_directed_cases();
    send_meas(cells_req(0, 0, 0, 0, 0, 32767));
    send_meas(cells_req(CELL_MAX, CELL_MAX, CELL_MAX, CELL_MAX, CELL_MAX, -32768));
    send_meas(cells_req(CELL_MAX, 0, 0, 0, 0, 2));
    send_meas(cells_req(CELL_MAX, 0, 0, 0, 0, 1));
    send_meas(cells_req(CELL_MAX, 0, 0, 0, 0, 2));
    send_meas(cells_req(CELL_MAX, 0, 0, 0, 0, -1));
    send_meas(cells_req(CELL_MAX, 0, 0, 0, 0, 0));
    send_meas(cells_req(0, 0, 0, 0, CELL_MAX, 2));
    send_meas(cells_req(V_NOM, V_NOM, V_NOM + 12500, V_NOM, V_NOM, 300));
    send_meas(cells_req(V_NOM, V_NOM, V_NOM + 12501, V_NOM, V_NOM, 300));
    send_meas(cells_req(V_NOM, V_NOM + 6250, V_NOM, V_NOM, V_NOM, 300));
    send_meas(cells_req(V_NOM, V_NOM + 6249, V_NOM, V_NOM, V_NOM, 300));
    send_meas(cells_req(V_NOM, V_NOM + 20000, V_NOM, V_NOM + 20000, V_NOM, 300));
    send_meas(cells_req(V_NOM, V_NOM + 20000, V_NOM, V_NOM + 20000, V_NOM, -2));
    send_meas(cells_req(23'h2AAAAA, 23'h555555, 23'h2AAAAA, 23'h555555, 23'h2AAAAA, 16'h5555));
    send_meas(cells_req(23'h555555, 23'h2AAAAA, 23'h555555, 23'h2AAAAA, 23'h555555, 16'hAAAA));
  endtask

  // Zero, large (1000000 uV) and crossed threshold settings
  task automatic test_threshold_extremes();
    settle();
    write_thresholds(0, 0);
    send_meas(cells_req(V_NOM + 1, V_NOM, V_NOM, V_NOM, V_NOM, 5));
    send_meas(cells_req(V_NOM, V_NOM, V_NOM, V_NOM, V_NOM, 5));
    send_meas(cells_req(0, 0, 0, 0, 0, 32767));
    settle();
    write_thresholds(1000000, 1000000);
    send_meas(cells_req(2250000, 1000000, 1000000, 1000000, 1000000, 9));
    send_meas(cells_req(1000000, 1000000, 1000000, 2250001, 1000000, 9));
    send_meas(cells_req(0, 0, 0, 0, CELL_MAX, 9));
    send_meas(cells_req(V_NOM, V_NOM, V_NOM, V_NOM, V_NOM, 9));
    settle();
    // low above high: the high test wins, otherwise the low one clears
    write_thresholds(5000, 20000);
    send_meas(cells_req(V_NOM, V_NOM + 10000, V_NOM, V_NOM, V_NOM, 40));
    send_meas(cells_req(V_NOM, V_NOM, V_NOM + 1000, V_NOM, V_NOM, 40));
    send_meas(cells_req(V_NOM, V_NOM, V_NOM, V_NOM + 6251, V_NOM, 40));
    send_meas(cells_req(V_NOM, V_NOM, V_NOM + 6250, V_NOM, V_NOM, 40));
    settle();
    write_thresholds(1000000, 0);
    send_meas(cells_req(0, 0, CELL_MAX, 0, 0, 3));
    send_meas(cells_req(V_NOM, V_NOM, V_NOM, V_NOM, V_NOM, 3));
  endtask

  // Random requests over several threshold settings, some phases without idling
  task automatic test_random_settings();
    int unsigned hi;
    int unsigned lo;
    for (int p = 0; p < 7; p++) begin
      settle();
      case (p)
        0: begin
          hi = $urandom_range(1000, 40000);
          lo = $urandom_range(0, hi);
        end
        1: begin
          hi = $urandom_range(0, 1000000);
          lo = $urandom_range(0, hi);
        end
        2: begin
          hi = $urandom_range(0, 20000);
          lo = hi + $urandom_range(1, 20000);
        end
        default: begin
          hi = $urandom_range(2000, 60000);
          lo = $urandom_range(0, hi);
        end
      endcase
      write_thresholds(hi, lo);
      burst = (p % 3 == 1);
      for (int n = 0; n < 230; n++) send_meas(rand_meas());
    end
    burst = 1'b0;
  endtask

  // Hold the output off for a long stretch while requests keep coming
  task automatic test_input_backpressure();
    settle();
    @(negedge clk);
    out_hold_cnt = HOLD_CYCLES;
    burst        = 1'b1;
    @(posedge clk);
    for (int n = 0; n < 40; n++) send_meas(rand_meas());
    burst = 1'b0;
  endtask

  // Accept results with random stalls and compare with the oldest prediction
  initial begin
    int       out_stall;
    bal_res_t exp_res;
    out_stall = 0;
    bal.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (bal.valid && bal.ready) begin
          if (balance_expect_q.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("unexpected result: mask=%b written=%b", bal.balance_mask,
                       bal.mask_written);
          end else begin
            exp_res = balance_expect_q.pop_front();
            if (exp_res.mask !== bal.balance_mask || exp_res.written !== bal.mask_written) begin
              fail_count++;
              if (fail_count <= REPORT_LIMIT)
                $display("mismatch: expected mask=%b written=%b, got mask=%b written=%b",
                         exp_res.mask, exp_res.written, bal.balance_mask, bal.mask_written);
            end
          end
          out_stall = burst ? 0 : $urandom_range(0, MAX_WAIT);
        end
        if (out_hold_cnt != 0) begin
          out_hold_cnt--;
          bal.ready <= 1'b0;
        end else if (out_stall != 0) begin
          out_stall--;
          bal.ready <= 1'b0;
        end else begin
          bal.ready <= 1'b1;
        end
      end
    end
  end

  // Count cycles without any transfer and stop a hung run
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (meas.valid && meas.ready) || (bal.valid && bal.ready) || (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // Reset, run the tests in turn, drain and report
  initial begin
    rst              <= 1'b1;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    meas.valid       <= 1'b0;
    meas.cell1_uv    <= '0;
    meas.cell2_uv    <= '0;
    meas.cell3_uv    <= '0;
    meas.cell4_uv    <= '0;
    meas.cell5_uv    <= '0;
    meas.current_raw <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_threshold_extremes();
    test_random_settings();
    test_input_backpressure();
    settle();
    if (fail_count == 0 && balance_expect_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
